// ===== rtl/radix2_fft_unit_macros.svh =====
// Assertion shorthands for the FFT block; clk and rst come from the module that uses them.
`ifndef RADIX2_FFT_UNIT_MACROS_SVH
`define RADIX2_FFT_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define R2F_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define R2F_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/r2f_pkg.sv =====
package r2f_pkg;

  localparam int MAX_LOG2_POINTS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int TWIDDLE_BITS    = 16;
  localparam int MAX_POINTS      = 1 << MAX_LOG2_POINTS;
  localparam int BIN_BITS        = SAMPLE_BITS + MAX_LOG2_POINTS;
  localparam int TW_FRAC         = TWIDDLE_BITS - 1;
  localparam int ADDR_W          = MAX_LOG2_POINTS;
  localparam int TW_ADDR_W       = MAX_LOG2_POINTS - 1;
  localparam int CFG_W           = 4;
  localparam int LOG2_RESET      = 10;

  // butterfly arithmetic widths
  localparam int PROD_W = BIN_BITS + TWIDDLE_BITS + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int T_W    = SUM_W - TW_FRAC;
  localparam int EXT_W  = T_W + 1;

  localparam real PI_VAL   = 3.14159265358979323846;
  localparam real PI_STEP  = PI_VAL / (MAX_POINTS / 2);
  localparam real TW_SCALE = 2.0 ** TW_FRAC;
  localparam int  TW_MAX   = (1 << TW_FRAC) - 1;

  typedef logic signed [TWIDDLE_BITS:0] tw_val_t;
  typedef tw_val_t tw_table_t [MAX_POINTS/2];

  typedef struct packed {
    logic                 ld_wr;
    logic [ADDR_W-1:0]    ld_addr;
    logic [ADDR_W-1:0]    addr_a;
    logic [ADDR_W-1:0]    addr_b;
    logic [TW_ADDR_W-1:0] tk;
    logic                 tw_load;
    logic                 mul1;
    logic                 mul2;
    logic                 add;
    logic                 wr_a;
    logic                 wr_b;
    logic                 out_load;
    logic                 out_valid_bin;
    logic [ADDR_W-1:0]    out_index;
    logic                 out_last;
  } r2f_cmd_t;

  typedef struct packed {
    logic out_busy;
  } r2f_stat_t;

  function automatic int tw_round(real x);
    int v;
    v = $rtoi(x * TW_SCALE + 0.5);
    if (v < 0) v = 0;
    if (v > TW_MAX) v = TW_MAX;
    return v;
  endfunction

  function automatic tw_table_t build_cos();
    tw_table_t t;
    int m;
    int v;
    for (int k = 0; k < MAX_POINTS / 2; k++) begin
      m = (k > MAX_POINTS / 4) ? (MAX_POINTS / 2 - k) : k;
      v = tw_round($cos(PI_STEP * m));
      if (k > MAX_POINTS / 4) v = -v;
      t[k] = tw_val_t'(v);
    end
    return t;
  endfunction

  function automatic tw_table_t build_sin();
    tw_table_t t;
    int m;
    for (int k = 0; k < MAX_POINTS / 2; k++) begin
      m = (k > MAX_POINTS / 4) ? (MAX_POINTS / 2 - k) : k;
      t[k] = tw_val_t'(tw_round($sin(PI_STEP * m)));
    end
    return t;
  endfunction

  localparam tw_table_t TW_COS = build_cos();
  localparam tw_table_t TW_SIN = build_sin();

  function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] x);
    logic [ADDR_W-1:0] r;
    for (int i = 0; i < ADDR_W; i++) begin
      r[i] = x[ADDR_W-1-i];
    end
    return r;
  endfunction

  function automatic logic signed [BIN_BITS-1:0] sat_bin(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = EXT_W'((64'sd1 <<< (BIN_BITS - 1)) - 64'sd1);
    lo = EXT_W'(-(64'sd1 <<< (BIN_BITS - 1)));
    if (v > hi) return hi[BIN_BITS-1:0];
    if (v < lo) return lo[BIN_BITS-1:0];
    return v[BIN_BITS-1:0];
  endfunction

endpackage

// ===== rtl/r2f_ctrl.sv =====
module r2f_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     action,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [r2f_pkg::CFG_W-1:0] cfg_data,
  output r2f_pkg::r2f_cmd_t        cmd,
  input  r2f_pkg::r2f_stat_t       stat
);
  import r2f_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_BF_RD, S_BF_M1, S_BF_M2, S_BF_ADD, S_BF_WA, S_BF_WB
  } state_t;

  state_t               state;
  logic [CFG_W-1:0]     log2_points;
  logic [ADDR_W-1:0]    load_count;
  logic [ADDR_W-1:0]    read_count;
  logic                 result_ready;
  logic [CFG_W-1:0]     stage;
  logic [TW_ADDR_W-1:0] bf;

  logic [CFG_W-1:0]  lg;
  logic [ADDR_W-1:0] n_mask;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] ridx;
  logic [ADDR_W-1:0] half;
  logic [ADDR_W-1:0] bf_w;
  logic [ADDR_W-1:0] low;
  logic [ADDR_W-1:0] addr_a;
  logic              accept;
  logic              bf_last;
  logic              in_bf;

  always_comb begin
    if (log2_points == '0) begin
      lg = CFG_W'(1);
    end else if (log2_points > CFG_W'(MAX_LOG2_POINTS)) begin
      lg = CFG_W'(MAX_LOG2_POINTS);
    end else begin
      lg = log2_points;
    end
  end

  assign n_mask  = {ADDR_W{1'b1}} >> (CFG_W'(MAX_LOG2_POINTS) - lg);
  assign pos     = load_count & n_mask;
  assign ridx    = read_count & n_mask;
  assign half    = ADDR_W'(1) << (stage - CFG_W'(1));
  assign bf_w    = ADDR_W'(bf);
  assign low     = bf_w & (half - ADDR_W'(1));
  assign addr_a  = ((bf_w >> (stage - CFG_W'(1))) << stage) | low;
  assign bf_last = (bf == TW_ADDR_W'(n_mask >> 1));
  assign in_bf   = (state != S_IDLE) && (state != S_READ);

  assign cfg_ready = (state == S_IDLE);
  // a pending config write takes the idle cycle
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cmd.ld_wr         = accept && !action;
    cmd.ld_addr       = bit_rev(pos) >> (CFG_W'(MAX_LOG2_POINTS) - lg);
    cmd.addr_a        = in_bf ? addr_a : ridx;
    cmd.addr_b        = addr_a | half;
    cmd.tk            = TW_ADDR_W'(low << (CFG_W'(MAX_LOG2_POINTS) - stage));
    cmd.tw_load       = (state == S_BF_RD);
    cmd.mul1          = (state == S_BF_M1);
    cmd.mul2          = (state == S_BF_M2);
    cmd.add           = (state == S_BF_ADD);
    cmd.wr_a          = (state == S_BF_WA);
    cmd.wr_b          = (state == S_BF_WB);
    cmd.out_load      = (state == S_READ) && !stat.out_busy;
    cmd.out_valid_bin = result_ready;
    cmd.out_index     = ridx;
    cmd.out_last      = (ridx == n_mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      log2_points  <= CFG_W'(LOG2_RESET);
      load_count   <= '0;
      read_count   <= '0;
      result_ready <= 1'b0;
      stage        <= CFG_W'(1);
      bf           <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            log2_points  <= cfg_data;
            load_count   <= '0;
            read_count   <= '0;
            result_ready <= 1'b0;
          end else if (accept) begin
            if (!action) begin
              result_ready <= 1'b0;
              if (pos == n_mask) begin
                load_count <= '0;
                read_count <= '0;
                stage      <= CFG_W'(1);
                bf         <= '0;
                state      <= S_BF_RD;
              end else begin
                load_count <= pos + ADDR_W'(1);
              end
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // hold until the output register frees up
          if (!stat.out_busy) begin
            if (result_ready) begin
              read_count <= (ridx == n_mask) ? '0 : ridx + ADDR_W'(1);
            end
            state <= S_IDLE;
          end
        end
        S_BF_RD:  state <= S_BF_M1;
        S_BF_M1:  state <= S_BF_M2;
        S_BF_M2:  state <= S_BF_ADD;
        S_BF_ADD: state <= S_BF_WA;
        S_BF_WA:  state <= S_BF_WB;
        S_BF_WB: begin
          if (bf_last) begin
            bf <= '0;
            if (stage == lg) begin
              result_ready <= 1'b1;
              state        <= S_IDLE;
            end else begin
              stage <= stage + CFG_W'(1);
              state <= S_BF_RD;
            end
          end else begin
            bf    <= bf + TW_ADDR_W'(1);
            state <= S_BF_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/r2f_datapath.sv =====
module r2f_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  r2f_pkg::r2f_cmd_t                   cmd,
  output r2f_pkg::r2f_stat_t                  stat,
  input  logic signed [r2f_pkg::SAMPLE_BITS-1:0] sample_re,
  input  logic signed [r2f_pkg::SAMPLE_BITS-1:0] sample_im,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [r2f_pkg::BIN_BITS-1:0] bin_re,
  output logic signed [r2f_pkg::BIN_BITS-1:0] bin_im,
  output logic [r2f_pkg::ADDR_W-1:0]          bin_index,
  output logic                                last_bin,
  output logic                                valid_bin
);
  import r2f_pkg::*;

  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (TW_FRAC - 1);

  logic [2*BIN_BITS-1:0] mem [MAX_POINTS];
  logic [2*BIN_BITS-1:0] q_a;
  logic [2*BIN_BITS-1:0] q_b;

  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [2*BIN_BITS-1:0] wdata;

  tw_val_t                    c_reg;
  tw_val_t                    s_reg;
  logic signed [BIN_BITS-1:0] ur, ui, br, bi;
  logic signed [BIN_BITS-1:0] qa_re, qa_im, qb_re, qb_im;
  logic signed [PROD_W-1:0]   p0, p1, p2, p3;
  logic signed [SUM_W-1:0]    sum_r, sum_i;
  logic signed [T_W-1:0]      tr, ti;
  logic signed [BIN_BITS-1:0] ya_re, ya_im, yb_re, yb_im;

  assign qa_re = q_a[2*BIN_BITS-1:BIN_BITS];
  assign qa_im = q_a[BIN_BITS-1:0];
  assign qb_re = q_b[2*BIN_BITS-1:BIN_BITS];
  assign qb_im = q_b[BIN_BITS-1:0];

  assign we    = cmd.ld_wr || cmd.wr_a || cmd.wr_b;
  assign waddr = cmd.ld_wr ? cmd.ld_addr : (cmd.wr_a ? cmd.addr_a : cmd.addr_b);

  always_comb begin
    if (cmd.ld_wr) begin
      wdata = {BIN_BITS'(sample_re), BIN_BITS'(sample_im)};
    end else if (cmd.wr_a) begin
      wdata = {ya_re, ya_im};
    end else begin
      wdata = {yb_re, yb_im};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_a <= mem[cmd.addr_a];
    q_b <= mem[cmd.addr_b];
  end

  assign sum_r = SUM_W'(p0) + SUM_W'(p1) + RND;
  assign sum_i = SUM_W'(p2) - SUM_W'(p3) + RND;
  assign tr    = T_W'(sum_r >>> TW_FRAC);
  assign ti    = T_W'(sum_i >>> TW_FRAC);

  always_ff @(posedge clk) begin
    if (cmd.tw_load) begin
      c_reg <= TW_COS[cmd.tk];
      s_reg <= TW_SIN[cmd.tk];
    end
    if (cmd.mul1) begin
      ur <= qa_re;
      ui <= qa_im;
      br <= qb_re;
      bi <= qb_im;
      p0 <= c_reg * qb_re;
      p1 <= s_reg * qb_im;
    end
    if (cmd.mul2) begin
      p2 <= c_reg * bi;
      p3 <= s_reg * br;
    end
    if (cmd.add) begin
      ya_re <= sat_bin(EXT_W'(ur) + EXT_W'(tr));
      ya_im <= sat_bin(EXT_W'(ui) + EXT_W'(ti));
      yb_re <= sat_bin(EXT_W'(ur) - EXT_W'(tr));
      yb_im <= sat_bin(EXT_W'(ui) - EXT_W'(ti));
    end
  end

  assign stat.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_valid_bin) begin
        bin_re    <= qa_re;
        bin_im    <= qa_im;
        bin_index <= cmd.out_index;
        last_bin  <= cmd.out_last;
        valid_bin <= 1'b1;
      end else begin
        bin_re    <= '0;
        bin_im    <= '0;
        bin_index <= '0;
        last_bin  <= 1'b0;
        valid_bin <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/radix2_fft_unit.sv =====
// channel  | handshake           | payload
// in       | in_valid / in_stall | action, sample_re, sample_im
// out      | out_valid/out_stall | bin_re, bin_im, bin_index, last_bin, valid_bin
// cfg      | cfg_valid/cfg_ready | cfg_data (log2_points)
//
// Loads are written from idle; a read item then waits in the read state while the output is busy.
// The load that completes a set starts the transform: each butterfly passes twiddle read, two
// multiply, add and two write states, the writes split by the single write port of the work memory.
// Reset clears control state only; the work memory needs no clearing pass.
// Input stalls during a transform, while a read item is in the read state, and while cfg_valid is high.
module radix2_fft_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  action,
  input  logic signed [r2f_pkg::SAMPLE_BITS-1:0] sample_re,
  input  logic signed [r2f_pkg::SAMPLE_BITS-1:0] sample_im,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [r2f_pkg::BIN_BITS-1:0]   bin_re,
  output logic signed [r2f_pkg::BIN_BITS-1:0]   bin_im,
  output logic [r2f_pkg::ADDR_W-1:0]            bin_index,
  output logic                                  last_bin,
  output logic                                  valid_bin,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [r2f_pkg::CFG_W-1:0]             cfg_data
);
  import r2f_pkg::*;

`include "radix2_fft_unit_macros.svh"

  r2f_cmd_t  cmd;
  r2f_stat_t stat;

  r2f_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  r2f_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .sample_re (sample_re),
    .sample_im (sample_im),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bin_re    (bin_re),
    .bin_im    (bin_im),
    .bin_index (bin_index),
    .last_bin  (last_bin),
    .valid_bin (valid_bin)
  );

  `R2F_ASSERT_NOW(a_empty_bin, out_valid && !valid_bin, bin_re == '0 && bin_im == '0 && bin_index == '0 && !last_bin, "bin without transform is not zero")
  `R2F_ASSERT_NEXT(a_read_waits, in_valid && !in_stall && action, in_stall, "read item did not block input")
  `R2F_ASSERT_NOW(a_one_writer, cmd.wr_a || cmd.wr_b, !cmd.ld_wr && in_stall, "load collides with butterfly write")

endmodule
